/* rtl/embedded_free_list_block_allocator_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the free-list block allocator
// Clocked assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EMBEDDED_FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH
`define EMBEDDED_FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define EFLBA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");
`define EFLBA_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define EFLBA_ASSERT(lbl, clk, rst_n, prop)
`define EFLBA_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* rtl/eflba_pkg.sv */
// ----------------------------------------------------------------------------
// eflba_pkg
// Types, codes and constants shared by the free-list block allocator.
// ----------------------------------------------------------------------------
package eflba_pkg;

	localparam int MAX_BLOCKS_DEF = 256;
	localparam int IDX_W          = 8;
	localparam int CNT_W          = 9;
	localparam int SIZE_W         = 16;
	localparam int OFFS_W         = 24;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 16;

	// Operation codes.
	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_OVER  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b1;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [IDX_W-1:0] free_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [IDX_W-1:0]  block_index;
		logic [OFFS_W-1:0] byte_offset;
		logic [IDX_W-1:0]  free_count;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic walk_start;
		logic walk_step;
		logic init_finish;
		logic alloc_issue;
		logic alloc_finish;
		logic alloc_empty;
		logic free_do;
		logic nop_do;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_done;
		logic pool_empty;
	} dp_stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INIT,
		S_ALLOC
	} state_t;

endpackage

/* rtl/eflba_datapath.sv */
// ----------------------------------------------------------------------------
// eflba_datapath
// Link memory, head and count registers, configuration registers, offset
// multiplier and the result register of the allocator.
// ----------------------------------------------------------------------------
module eflba_datapath #(
	parameter int MAX_BLOCKS = eflba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  eflba_pkg::ctl_t                     ctl,
	input  logic [eflba_pkg::IDX_W-1:0]         free_index,
	input  logic                                cfg_we,
	input  logic [eflba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [eflba_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output eflba_pkg::dp_stat_t                 stat,
	output logic                                done,
	output eflba_pkg::result_t                  result
);
	import eflba_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

	logic [IDX_W-1:0]  mem [MAX_BLOCKS];

	logic [IDX_W-1:0]  nb_q;
	logic [SIZE_W-1:0] bs_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  total_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic [IDX_W-1:0]  rd_q;
	logic              rd_ok_q;
	logic [IDX_W-1:0]  bidx_q;
	logic [OFFS_W-1:0] prod_q;
	result_t           result_q;

	logic [IDX_W-1:0]  head_d;
	logic [IDX_W-1:0]  total_d;
	result_t           res_d;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [IDX_W-1:0]  mem_wdata;
	logic              free_ok;
	logic              emit;

	assign free_ok = (free_index < nb_q) && ({1'b0, free_index} < MAX_CNT);
	assign emit    = ctl.init_finish | ctl.alloc_finish | ctl.alloc_empty |
	                 ctl.free_do | ctl.nop_do;

	assign stat.walk_done  = !((cnt_q < {1'b0, nb_q}) && (cnt_q < MAX_CNT));
	assign stat.pool_empty = (total_q == '0);

	always_comb begin
		head_d            = head_q;
		total_d           = total_q;
		res_d.status      = STAT_OK;
		res_d.block_index = '0;
		res_d.byte_offset = '0;
		res_d.free_count  = total_q;
		mem_we            = 1'b0;
		mem_waddr         = free_index[AW-1:0];
		mem_wdata         = head_q;
		if (ctl.walk_step) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[AW-1:0];
			mem_wdata = cnt_q[IDX_W-1:0] + 8'd1;
		end else if (ctl.init_finish) begin
			head_d           = '0;
			total_d          = nb_q;
			res_d.free_count = nb_q;
		end else if (ctl.alloc_empty) begin
			res_d.status = STAT_EMPTY;
		end else if (ctl.alloc_finish) begin
			// A head beyond the link memory has no stored link and reads as zero.
			head_d            = rd_ok_q ? rd_q : '0;
			total_d           = total_q - 8'd1;
			res_d.block_index = bidx_q;
			res_d.byte_offset = prod_q;
			res_d.free_count  = total_q - 8'd1;
		end else if (ctl.free_do) begin
			if (!free_ok) begin
				res_d.status = STAT_RANGE;
			end else begin
				mem_we = 1'b1;
				head_d = free_index;
				if (total_q >= nb_q) begin
					res_d.status = STAT_OVER;
				end else begin
					total_d          = total_q + 8'd1;
					res_d.free_count = total_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q    <= 8'd255;
			bs_q    <= 16'd16;
			head_q  <= '0;
			total_q <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NUM_BLOCKS: nb_q <= cfg_wdata[IDX_W-1:0];
					CFG_BLOCK_SIZE: bs_q <= cfg_wdata[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (ctl.walk_start) begin
				cnt_q <= '0;
			end else if (ctl.walk_step) begin
				cnt_q <= cnt_q + 9'd1;
			end
			head_q  <= head_d;
			total_q <= total_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (ctl.alloc_issue) begin
			rd_q    <= mem[head_q[AW-1:0]];
			rd_ok_q <= ({1'b0, head_q} < MAX_CNT);
			bidx_q  <= head_q;
			prod_q  <= OFFS_W'(head_q) * OFFS_W'(bs_q);
		end
		if (emit) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* rtl/eflba_ctrl.sv */
// ----------------------------------------------------------------------------
// eflba_ctrl
// Operation sequencer: decodes accepted items and steps the datapath through
// the init walk and the allocate.
// ----------------------------------------------------------------------------
module eflba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          opcode,
	input  eflba_pkg::dp_stat_t stat,
	output logic                busy,
	output eflba_pkg::ctl_t     ctl
);
	import eflba_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (opcode)
						OP_INIT: begin
							ctl.walk_start = 1'b1;
							state_d        = S_INIT;
						end
						OP_ALLOC: begin
							if (stat.pool_empty) begin
								ctl.alloc_empty = 1'b1;
							end else begin
								ctl.alloc_issue = 1'b1;
								state_d         = S_ALLOC;
							end
						end
						OP_FREE: ctl.free_do = 1'b1;
						OP_NOP:  ctl.nop_do  = 1'b1;
						default: ;
					endcase
				end
			end
			S_INIT: begin
				if (stat.walk_done) begin
					ctl.init_finish = 1'b1;
					state_d         = S_IDLE;
				end else begin
					ctl.walk_step = 1'b1;
				end
			end
			S_ALLOC: begin
				ctl.alloc_finish = 1'b1;
				state_d          = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/embedded_free_list_block_allocator.sv */
// ----------------------------------------------------------------------------
// embedded_free_list_block_allocator
// Fixed-size block allocator with a LIFO free list held in a link memory.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   command  | start, busy          | cmd (opcode, free_index)
//   result   | done (one cycle)     | result (status, block_index,
//            |                      |   byte_offset, free_count)
//   config   | cfg_we               | cfg_index, cfg_wdata
//
// Free, no-op and allocate on an empty pool are answered from idle; the result shows
// the cycle after the item is taken and a new item may be taken in that cycle.
// Allocate otherwise reads the link memory into a register, then finishes in S_ALLOC.
// Init writes min(num_blocks, MAX_BLOCKS) links, one link written a cycle.
// After reset the pool is empty until an init or a free; busy stays high while working.
// done marks each result for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module embedded_free_list_block_allocator #(
	parameter int MAX_BLOCKS = eflba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  eflba_pkg::cmd_t                  cmd,
	output logic                             busy,
	output logic                             done,
	output eflba_pkg::result_t               result,
	input  logic                             cfg_we,
	input  logic [eflba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [eflba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import eflba_pkg::*;

`include "embedded_free_list_block_allocator_defines.svh"

	ctl_t     ctl;
	dp_stat_t stat;
	logic     quick_op;
	logic     empty_res;
	logic     granted;

	assign quick_op  = start && !busy && (cmd.opcode == OP_FREE || cmd.opcode == OP_NOP);
	assign empty_res = done && (result.status == STAT_EMPTY);
	assign granted   = (result.block_index != '0) || (result.byte_offset != '0);

	eflba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (cmd.opcode),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	eflba_datapath #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.free_index (cmd.free_index),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.stat       (stat),
		.done       (done),
		.result     (result)
	);

	// A free or no-op item is answered in the very next cycle.
	`EFLBA_ASSERT(a_quick_result, clk, arst_n, quick_op |=> done)
	// A granted allocate holds the block busy in S_ALLOC, then answers.
	`EFLBA_ASSERT(a_alloc_timing, clk, arst_n, ctl.alloc_issue |=> (busy && !done) ##1 (done && !busy))
	// An empty pool reports a zero count.
	`EFLBA_ASSERT(a_empty_count, clk, arst_n, empty_res |-> (result.free_count == '0))
	// Only a successful allocate carries a block index or offset.
	`EFLBA_NEVER(a_fail_no_grant, clk, arst_n, done && result.status != STAT_OK && granted)

endmodule
